### sv/ring_timeseries_window_stats_top_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the ring time-series window statistics block
// ----------------------------------------------------------------------------
`ifndef RING_TIMESERIES_WINDOW_STATS_TOP_MACROS_SVH
`define RING_TIMESERIES_WINDOW_STATS_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define RTWS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define RTWS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rtws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtws_pkg
// shared constants and types of the ring time-series window statistics block
// ----------------------------------------------------------------------------
package rtws_pkg;

  localparam int unsigned RTWS_RING_DEPTH   = 64;
  localparam int unsigned RTWS_SERIES_COUNT = 3;

  // payload field widths
  localparam int unsigned SERIES_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned WINDOW_W = 7;
  localparam int unsigned INC_W    = 33;
  localparam int unsigned MEAN_W   = 40;
  localparam int unsigned FRAC_W   = 8;

  // one stored entry: valid mark above the value
  localparam int unsigned ENTRY_W = VALUE_W + 1;

  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 144;

  // request kinds
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // result status
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_UNKNOWN = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### sv/ring_timeseries_window_stats_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_timeseries_window_stats_top
// circular sample rings per series with window min, increase and averages
// ----------------------------------------------------------------------------
//  channel   dir  tuser     tdata (lowest bit up)
//  s_axis    in   req_type  series, sample, stamp_sec, window
//  m_axis    out  status    min_found, min_value, increase, mean_found,
//                           mean_window, mean_all
//
//  after reset a clearing pass empties all SERIES_COUNT*RING_DEPTH entries,
//  one per cycle, and no beat is taken meanwhile
//  append or unknown series: handled by the write and the result stage
//  query: one memory read per entry walked, then the one-bit-per-cycle
//  divider twice, once per mean, each run skipped when its count is zero
//  one beat at a time; a finished result waits in the output register while
//  the next beat is taken, and only a second finished result stalls
// ----------------------------------------------------------------------------
module ring_timeseries_window_stats_top #(
  parameter int unsigned RING_DEPTH   = rtws_pkg::RTWS_RING_DEPTH,
  parameter int unsigned SERIES_COUNT = rtws_pkg::RTWS_SERIES_COUNT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // series[1:0], sample[33:2], stamp_sec[65:34], window[72:66]
  input  logic [rtws_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // req_type
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // min_found[0], min_value[32:1], increase[65:33], mean_found[66],
  // mean_window[106:67], mean_all[138:107]
  output logic [rtws_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // status
  output logic                               m_axis_tuser
);
  import rtws_pkg::*;

  localparam int unsigned ENTRIES = SERIES_COUNT * RING_DEPTH;
  localparam int unsigned AW      = $clog2(ENTRIES);
  localparam int unsigned IW      = $clog2(RING_DEPTH);
  localparam int unsigned CW      = $clog2(RING_DEPTH + 1);
  localparam int unsigned SEL_W   = (SERIES_COUNT > 1) ? $clog2(SERIES_COUNT) : 1;
  localparam int unsigned SUM_W   = VALUE_W + CW;
  localparam int unsigned DW      = SUM_W + FRAC_W;

  localparam logic [2:0] ST_CLEAR     = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_WALK      = 3'd2;
  localparam logic [2:0] ST_DIVW_GO   = 3'd3;
  localparam logic [2:0] ST_DIVW_WAIT = 3'd4;
  localparam logic [2:0] ST_DIVA_GO   = 3'd5;
  localparam logic [2:0] ST_DIVA_WAIT = 3'd6;
  localparam logic [2:0] ST_DONE      = 3'd7;

  // input fields
  logic [SERIES_W-1:0] in_series;
  logic [VALUE_W-1:0]  in_sample;
  logic [VALUE_W-1:0]  in_stamp;
  logic [WINDOW_W-1:0] in_window;

  assign in_series = s_axis_tdata[1:0];
  assign in_sample = s_axis_tdata[33:2];
  assign in_stamp  = s_axis_tdata[65:34];
  assign in_window = s_axis_tdata[72:66];

  logic [2:0]         state_q, state_d;
  logic [IW-1:0]      wp_q [SERIES_COUNT];
  logic               accept;
  logic               known;
  logic [SEL_W-1:0]   sel_in;
  logic [IW-1:0]      wp_in;
  logic [AW:0]        base_full;
  logic [AW-1:0]      base_in;
  logic [CW-1:0]      win_sat;

  // walk state
  logic [AW-1:0]      base_q;
  logic [IW-1:0]      idx_q;
  logic [CW-1:0]      issue_q;
  logic               rvalid_q;
  logic [CW-1:0]      ri_q;
  logic [CW-1:0]      win_q;
  logic [CW-1:0]      old_pos;
  logic               issuing;
  logic               walk_last;

  // accumulators
  logic               run_q;
  logic [VALUE_W-1:0] min_q;
  logic [SUM_W-1:0]   sum_q;
  logic [CW-1:0]      cnt_q;
  logic [SUM_W-1:0]   tsum_q;
  logic [CW-1:0]      tcnt_q;
  logic               newest_vld_q;
  logic [VALUE_W-1:0] newest_q;
  logic               old_vld_q;
  logic [VALUE_W-1:0] old_q;

  // results
  logic               zero_q;
  logic               status_q;
  logic [INC_W-1:0]   inc_q;
  logic [MEAN_W-1:0]  mean_win_q;
  logic [VALUE_W-1:0] mean_all_q;

  logic                    out_vld_q;
  logic [OUT_TDATA_W-1:0]  out_data_q;
  logic                    out_user_q;
  logic                    out_load;

  // memory and divider hookup
  logic               ring_ready;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;
  logic [VALUE_W-1:0] rd_value;
  logic               rd_valid;
  logic               div_start;
  logic [DW-1:0]      div_dividend;
  logic [CW-1:0]      div_divisor;
  logic [DW-1:0]      div_quotient;
  div_stat_t          div_stat;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign known         = {30'd0, in_series} < 32'(SERIES_COUNT);
  assign sel_in        = SEL_W'(in_series);
  assign wp_in         = wp_q[sel_in];
  assign base_full     = (AW + 1)'(sel_in) * (AW + 1)'(RING_DEPTH);
  assign base_in       = base_full[AW-1:0];
  assign win_sat       = (32'(in_window) > RING_DEPTH) ? CW'(RING_DEPTH) : CW'(in_window);

  assign wr_en   = accept && known && (s_axis_tuser == REQ_APPEND);
  assign wr_addr = base_in + AW'(wp_in);
  assign wr_data = {in_stamp != '0, in_sample};

  assign issuing   = (state_q == ST_WALK) && (issue_q != CW'(RING_DEPTH));
  assign walk_last = rvalid_q && (ri_q == CW'(RING_DEPTH - 1));
  // a full-depth window wraps around to the newest entry
  assign old_pos   = (win_q == CW'(RING_DEPTH)) ? '0 : win_q;
  assign rd_value  = rd_data[VALUE_W-1:0];
  assign rd_valid  = rd_data[VALUE_W];

  assign div_start    = ((state_q == ST_DIVW_GO) && (cnt_q != '0)) ||
                        ((state_q == ST_DIVA_GO) && (tcnt_q != '0));
  assign div_dividend = (state_q == ST_DIVW_GO) ? {sum_q, {FRAC_W{1'b0}}} : DW'(tsum_q);
  assign div_divisor  = (state_q == ST_DIVW_GO) ? cnt_q : tcnt_q;

  assign out_load = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready);

  rtws_ring #(
    .ENTRIES (ENTRIES),
    .ADDR_W  (AW)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (issuing),
    .rd_addr_i (base_q + AW'(idx_q)),
    .rd_data_o (rd_data),
    .ready_o   (ring_ready)
  );

  rtws_div #(
    .DIVIDEND_W (DW),
    .DIVISOR_W  (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quotient),
    .stat_o     (div_stat)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (ring_ready) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = (known && (s_axis_tuser == REQ_QUERY)) ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        if (walk_last) state_d = ST_DIVW_GO;
      end
      ST_DIVW_GO: begin
        state_d = (cnt_q != '0) ? ST_DIVW_WAIT : ST_DIVA_GO;
      end
      ST_DIVW_WAIT: begin
        if (div_stat.done) state_d = ST_DIVA_GO;
      end
      ST_DIVA_GO: begin
        state_d = (tcnt_q != '0) ? ST_DIVA_WAIT : ST_DONE;
      end
      ST_DIVA_WAIT: begin
        if (div_stat.done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      out_vld_q <= 1'b0;
      rvalid_q  <= 1'b0;
      issue_q   <= '0;
      for (int s = 0; s < SERIES_COUNT; s++) begin
        wp_q[s] <= '0;
      end
    end else begin
      state_q  <= state_d;
      rvalid_q <= issuing;
      if (wr_en) begin
        wp_q[sel_in] <= (wp_in == IW'(RING_DEPTH - 1)) ? '0 : wp_in + 1'b1;
      end
      if (accept) begin
        issue_q <= '0;
      end else if (issuing) begin
        issue_q <= issue_q + 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      zero_q     <= !(known && (s_axis_tuser == REQ_QUERY));
      status_q   <= known ? STATUS_OK : STATUS_UNKNOWN;
      base_q     <= base_in;
      idx_q      <= (wp_in == '0) ? IW'(RING_DEPTH - 1) : wp_in - 1'b1;
      win_q      <= win_sat;
      run_q      <= 1'b1;
      min_q      <= '0;
      sum_q      <= '0;
      cnt_q      <= '0;
      tsum_q     <= '0;
      tcnt_q     <= '0;
      mean_win_q <= '0;
      mean_all_q <= '0;
    end
    if (issuing) begin
      ri_q  <= issue_q;
      idx_q <= (idx_q == '0) ? IW'(RING_DEPTH - 1) : idx_q - 1'b1;
    end
    if (rvalid_q) begin
      if (ri_q == '0) begin
        newest_vld_q <= rd_valid;
        newest_q     <= rd_value;
      end
      if (ri_q == old_pos) begin
        old_vld_q <= rd_valid;
        old_q     <= rd_value;
      end
      // the run stops at the first empty entry inside the window
      if (run_q && (ri_q < win_q)) begin
        if (rd_valid) begin
          if ((cnt_q == '0) || (rd_value < min_q)) min_q <= rd_value;
          sum_q <= sum_q + SUM_W'(rd_value);
          cnt_q <= cnt_q + 1'b1;
        end else begin
          run_q <= 1'b0;
        end
      end
      if (rd_valid) begin
        tsum_q <= tsum_q + SUM_W'(rd_value);
        tcnt_q <= tcnt_q + 1'b1;
      end
    end
    if (state_q == ST_DIVW_GO) begin
      if (!newest_vld_q) begin
        inc_q <= '0;
      end else if (old_vld_q) begin
        inc_q <= {1'b0, newest_q} - {1'b0, old_q};
      end else begin
        inc_q <= {1'b0, newest_q};
      end
    end
    if ((state_q == ST_DIVW_WAIT) && div_stat.done) begin
      mean_win_q <= div_quotient[MEAN_W-1:0];
    end
    if ((state_q == ST_DIVA_WAIT) && div_stat.done) begin
      mean_all_q <= div_quotient[VALUE_W-1:0];
    end
    if (out_load) begin
      out_user_q <= status_q;
      if (zero_q) begin
        out_data_q <= '0;
      end else begin
        out_data_q <= OUT_TDATA_W'({mean_all_q, mean_win_q, cnt_q != '0, inc_q,
                                    min_q, cnt_q != '0});
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  `include "ring_timeseries_window_stats_top_macros.svh"

  `RTWS_ASSERT_IMP(a_no_beat_while_clearing, !ring_ready, !s_axis_tready, "beat taken during clear")
  `RTWS_ASSERT_IMP(a_error_result_empty, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "error result carries data")
  `RTWS_ASSERT_IMP(a_found_flags_agree, m_axis_tvalid, m_axis_tdata[0] == m_axis_tdata[66], "min and mean found flags differ")
  `RTWS_ASSERT_NXT(a_walk_ends, (state_q == ST_WALK) && walk_last, state_q == ST_DIVW_GO, "walk did not hand over to divider")

endmodule

### sv/rtws_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtws_ring
// sample store for all series, one write and one registered read per cycle,
// swept to empty entries after reset
// ----------------------------------------------------------------------------
module rtws_ring #(
  parameter int unsigned ENTRIES = 192,
  parameter int unsigned ADDR_W  = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [ADDR_W-1:0]           wr_addr_i,
  input  logic [rtws_pkg::ENTRY_W-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [ADDR_W-1:0]           rd_addr_i,
  output logic [rtws_pkg::ENTRY_W-1:0] rd_data_o,
  output logic                        ready_o
);
  import rtws_pkg::*;

  logic [ENTRY_W-1:0] mem [ENTRIES];
  logic [ENTRY_W-1:0] rd_data_q;
  logic               clr_q;
  logic [ADDR_W-1:0]  clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == ADDR_W'(ENTRIES - 1)) begin
        clr_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = !clr_q;

endmodule

### sv/rtws_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtws_div
// restoring divider, one quotient bit per cycle, shared by both averages
// ----------------------------------------------------------------------------
module rtws_div #(
  parameter int unsigned DIVIDEND_W = 47,
  parameter int unsigned DIVISOR_W  = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output rtws_pkg::div_stat_t   stat_o
);
  import rtws_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [STEP_W-1:0]     step_q;
  logic [DIVIDEND_W-1:0] dq_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  divisor_q;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign trial = {rem_q, dq_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign fits  = trial >= {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so it fits the divisor width
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q      <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DIVIDEND_W-2:0], fits};
      rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign quotient_o  = dq_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  `include "ring_timeseries_window_stats_top_macros.svh"

  `RTWS_ASSERT_IMP(a_div_no_restart, start_i, !busy_q, "divider restarted while busy")
  `RTWS_ASSERT_NXT(a_div_starts, start_i, busy_q && step_q == '0, "divider did not start")
  `RTWS_ASSERT_IMP(a_div_nonzero, busy_q, divisor_q != '0, "divide by zero")
  `RTWS_ASSERT_NXT(a_div_done_pulse, done_q, !done_q, "done held more than one cycle")

endmodule
